// ----- design/i8mvm_pkg.sv -----
// ----------------------------------------------------------------------------
// i8mvm_pkg
// Shared types and constants for the int8 matrix-vector multiply core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i8mvm_pkg;

    localparam int LANES       = 8;
    localparam int MAX_K_DEF   = 4096;
    localparam int MAX_N       = 4096;
    localparam int CFG_W       = 13;
    localparam int IDX_W       = 12;
    localparam int VAL_W       = 8;
    localparam int CHAN_W      = 12;
    localparam int SUM_W       = 28;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_W-1:0] K_LEN_RESET = CFG_W'(64);
    localparam logic [CFG_W-1:0] N_LEN_RESET = CFG_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_K_LEN = 1'b0,
        REG_N_LEN = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        KIND_ACT    = 1'b0,
        KIND_WEIGHT = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         act_index;
        logic signed [VAL_W-1:0]  act_value;
        logic signed [VAL_W-1:0]  weight_0;
        logic signed [VAL_W-1:0]  weight_1;
        logic signed [VAL_W-1:0]  weight_2;
        logic signed [VAL_W-1:0]  weight_3;
        logic signed [VAL_W-1:0]  weight_4;
        logic signed [VAL_W-1:0]  weight_5;
        logic signed [VAL_W-1:0]  weight_6;
        logic signed [VAL_W-1:0]  weight_7;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_W-1:0]        channel;
        logic signed [SUM_W-1:0]  sum;
        logic                     last;
    } t_out_word;

    // per-cycle strobes from the sequencer to every lane
    typedef struct packed {
        logic load;   // capture weight of an accepted beat
        logic mul;    // form product of the first stage
        logic acc;    // fold product into the accumulator
        logic clear;  // product closes the group
    } t_lane_ctrl;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAN_W-1:0] base;
    } t_stage;

endpackage

`default_nettype wire

// ----- design/i8mvm_lane.sv -----
// ----------------------------------------------------------------------------
// i8mvm_lane
// One multiply-accumulate lane: weight register, product register and
// accumulator. The running total including the pending product is exposed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i8mvm_lane
    import i8mvm_pkg::*;
#(
    parameter int ACC_W = SUM_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_lane_ctrl               i_ctrl,
    input  wire logic signed [VAL_W-1:0]  i_weight,
    input  wire logic signed [VAL_W-1:0]  i_act,
    output logic signed [ACC_W-1:0]       o_total
);

    logic signed [VAL_W-1:0]  r_weight;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_weight <= i_weight;
        end
        if (i_ctrl.mul) begin
            r_prod <= r_weight * i_act;
        end
    end

    assign o_total = r_acc + ACC_W'(r_prod);

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.acc) begin
            n_acc = i_ctrl.clear ? '0 : o_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

`default_nettype wire

// ----- design/i8mvm_merge.sv -----
// ----------------------------------------------------------------------------
// i8mvm_merge
// Result bank: takes the eight lane sums of a finished group at once and
// hands them out one word per cycle in lane order while i_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i8mvm_merge
    import i8mvm_pkg::*;
#(
    parameter int ACC_W = SUM_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_load,
    input  wire logic signed [ACC_W-1:0]  i_sums [LANES],
    input  wire logic [CHAN_W-1:0]        i_base,
    output logic                          o_free,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output t_out_word                     o_data
);

    localparam int LW = $clog2(LANES);
    localparam int CW = $clog2(LANES + 1);

    logic signed [ACC_W-1:0] r_bank [LANES];
    logic [CHAN_W-1:0]       r_base;
    logic [LW-1:0]           r_idx;
    logic [CW-1:0]           r_cnt;
    logic                    w_take;

    assign o_valid = (r_cnt != '0);
    assign w_take  = o_valid && !i_stall;
    assign o_free  = (r_cnt == '0) || ((r_cnt == CW'(1)) && !i_stall);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bank <= i_sums;
            r_base <= i_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= CW'(LANES);
            r_idx <= '0;
        end else if (w_take) begin
            r_cnt <= r_cnt - CW'(1);
            r_idx <= r_idx + LW'(1);
        end
    end

    always_comb begin
        o_data.channel = r_base + CHAN_W'(r_idx);
        o_data.sum     = SUM_W'(r_bank[r_idx]);
        o_data.last    = (r_idx == LW'(LANES - 1));
    end

endmodule

`default_nettype wire

// ----- design/int8_matrix_vector_multiply_core.sv -----
// Result path: a group's last weight beat passes stages s1 and s2, then the
//   bank loads; the eight words follow one per cycle while i_stall is low.
// Throughput: one input word per cycle while o_stall is low; each group puts
//   8 words on the single output port; groups under 8 beats are paced by it.
// Reset: synchronous, active low; presets k/n lengths; clears position, channel
//   base, stages, accumulators, bank count. The activation memory is not cleared.
// ----------------------------------------------------------------------------
// int8_matrix_vector_multiply_core
// Signed int8 matrix-vector product with eight parallel MAC lanes and a
// result bank that serializes the lane sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module int8_matrix_vector_multiply_core
    import i8mvm_pkg::*;
#(
    parameter int MAX_K = MAX_K_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in_word              i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out_word                  o_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int AW    = $clog2(MAX_K);
    localparam int KW    = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int ACC_W = AW + PROD_W;

    logic signed [VAL_W-1:0] r_mem [MAX_K];
    logic signed [VAL_W-1:0] r_act;

    logic [CFG_W-1:0]  r_k_len;
    logic [CFG_W-1:0]  r_n_len;
    logic [AW-1:0]     r_pos;
    logic [CHAN_W-1:0] r_base;
    t_stage            r_s1;
    t_stage            r_s2;

    logic              w_en;
    logic              w_acc;
    logic              w_beat;
    logic              w_grp_end;
    logic [KW-1:0]     w_eff_k;
    logic [CFG_W-1:0]  w_eff_n;
    logic [CFG_W-1:0]  w_base_step;
    logic              w_merge_free;
    logic              w_merge_load;
    t_lane_ctrl        w_ctrl;

    logic signed [VAL_W-1:0] w_weights [LANES];
    logic signed [ACC_W-1:0] w_totals  [LANES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_len <= K_LEN_RESET;
            r_n_len <= N_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_K_LEN: r_k_len <= i_cfg_data;
                REG_N_LEN: r_n_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective lengths: clamp k to 1..MAX_K, n to a lane multiple in LANES..MAX_N
    always_comb begin
        w_eff_k = KW'(r_k_len);
        if (w_eff_k == '0) begin
            w_eff_k = KW'(1);
        end
        if (w_eff_k > KW'(MAX_K)) begin
            w_eff_k = KW'(MAX_K);
        end
        w_eff_n = r_n_len;
        if (w_eff_n > CFG_W'(MAX_N)) begin
            w_eff_n = CFG_W'(MAX_N);
        end
        w_eff_n = w_eff_n & ~CFG_W'(LANES - 1);
        if (w_eff_n < CFG_W'(LANES)) begin
            w_eff_n = CFG_W'(LANES);
        end
        w_base_step = CFG_W'(r_base) + CFG_W'(2 * LANES);
    end

    // hold the whole pipeline while a finished group waits for the result bank
    assign w_merge_load = r_s2.valid && r_s2.last && w_merge_free;
    assign w_en         = !(r_s2.valid && r_s2.last && !w_merge_free);
    assign o_stall      = !w_en;
    assign w_acc        = i_valid && !o_stall;
    assign w_beat       = w_acc && (i_data.kind == KIND_WEIGHT);
    assign w_grp_end    = (KW'(r_pos) + KW'(1)) >= w_eff_k;

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_data.kind == KIND_ACT)
                && (32'(i_data.act_index) < 32'(MAX_K))) begin
            r_mem[AW'(i_data.act_index)] <= i_data.act_value;
        end
        if (w_beat) begin
            r_act <= r_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_base <= '0;
        end else if (w_beat) begin
            if (w_grp_end) begin
                r_pos  <= '0;
                r_base <= (w_base_step > w_eff_n) ? '0 : r_base + CHAN_W'(LANES);
            end else begin
                r_pos <= r_pos + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (w_en) begin
            r_s1.valid <= w_beat;
            r_s1.last  <= w_grp_end;
            r_s1.base  <= r_base;
            r_s2       <= r_s1;
        end
    end

    always_comb begin
        w_ctrl.load  = w_beat;
        w_ctrl.mul   = w_en && r_s1.valid;
        w_ctrl.acc   = w_en && r_s2.valid;
        w_ctrl.clear = r_s2.last;
    end

    always_comb begin
        w_weights[0] = i_data.weight_0;
        w_weights[1] = i_data.weight_1;
        w_weights[2] = i_data.weight_2;
        w_weights[3] = i_data.weight_3;
        w_weights[4] = i_data.weight_4;
        w_weights[5] = i_data.weight_5;
        w_weights[6] = i_data.weight_6;
        w_weights[7] = i_data.weight_7;
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        i8mvm_lane #(
            .ACC_W (ACC_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_weight (w_weights[g]),
            .i_act    (r_act),
            .o_total  (w_totals[g])
        );
    end

    i8mvm_merge #(
        .ACC_W (ACC_W)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_merge_load),
        .i_sums  (w_totals),
        .i_base  (r_s2.base),
        .o_free  (w_merge_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    a_stall_only_on_blocked_group: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s2.valid && r_s2.last)
    ) else $error("input stalled without a group waiting for the result bank");

    a_position_wraps: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && w_grp_end) |=> (r_pos == '0)
    ) else $error("position did not return to zero at group end");

    a_position_advances: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && !w_grp_end) |=> (r_pos == $past(r_pos + AW'(1)))
    ) else $error("position did not advance on a weight word");

    a_no_output_after_reset: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_valid
    ) else $error("output word valid right after reset");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the int8 matrix-vector multiply core. A short table
// of words exercises operand extremes at a one-beat dot product, then random
// groups run under a range of size settings, some left open across a change.
// Each sum word is checked against an in-bench MAC model or a typed row's sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import i8mvm_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int N_DIRECTED    = 16;
    localparam int N_PHASES      = 11;

    typedef struct packed {
        t_in_word                word;
        bit                      typed;
        logic signed [SUM_W-1:0] want;
    } t_table_row;

    typedef struct packed {
        logic [CFG_W-1:0] k_val;
        logic [CFG_W-1:0] n_val;
        int               beats;
        int               idle;
        bit               hold;
    } t_size_phase;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_in_word             i_data;
    logic                 o_valid;
    logic                 i_stall;
    t_out_word            o_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // MAC model state
    logic signed [VAL_W-1:0] act_mem [MAX_K_DEF];
    bit                      act_written [MAX_K_DEF];
    longint                  lane_acc [LANES];
    int unsigned             cur_pos;
    int unsigned             cur_base;
    logic [CFG_W-1:0]        k_reg;
    logic [CFG_W-1:0]        n_reg;
    t_out_word               pending_sums [$];

    int  idle_pct;
    bit  hold_request;
    int  errors;
    int  sums_checked;
    int  beats_sent;
    int  writes_sent;

    t_table_row  dir_rows [N_DIRECTED];
    t_size_phase phases [N_PHASES];

    int8_matrix_vector_multiply_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned k_span();
        int unsigned k;
        k = k_reg;
        if (k == 0) k = 1;
        if (k > MAX_K_DEF) k = MAX_K_DEF;
        return k;
    endfunction

    function automatic int unsigned n_span();
        int unsigned n;
        n = n_reg;
        if (n > MAX_N) n = MAX_N;
        n -= n % LANES;
        if (n < LANES) n = LANES;
        return n;
    endfunction

    // Fold one accepted word into the model; a closing beat queues eight sums.
    function automatic void mac_update(t_in_word w, bit typed, logic signed [SUM_W-1:0] want);
        logic [8*LANES-1:0] wv;
        longint             a_val;
        t_out_word          sum_word;
        if (w.kind == KIND_ACT) begin
            act_mem[w.act_index]     = w.act_value;
            act_written[w.act_index] = 1'b1;
        end else begin
            wv = {w.weight_0, w.weight_1, w.weight_2, w.weight_3,
                  w.weight_4, w.weight_5, w.weight_6, w.weight_7};
            a_val = act_mem[cur_pos];
            for (int l = 0; l < LANES; l++)
                lane_acc[l] += longint'($signed(wv[8*(LANES-1-l) +: 8])) * a_val;
            if (cur_pos + 1 < k_span()) begin
                cur_pos++;
            end else begin
                for (int l = 0; l < LANES; l++) begin
                    sum_word.channel = CHAN_W'(cur_base + l);
                    sum_word.sum     = typed ? want : SUM_W'(lane_acc[l]);
                    sum_word.last    = (l == LANES - 1);
                    pending_sums.push_back(sum_word);
                    lane_acc[l] = 0;
                end
                cur_pos = 0;
                if (cur_base + 2 * LANES > n_span())
                    cur_base = 0;
                else
                    cur_base += LANES;
            end
        end
    endfunction

    function automatic logic [VAL_W-1:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h80;
            1: return 8'h7F;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic t_in_word mk_act(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
        t_in_word w;
        w.kind      = KIND_ACT;
        w.act_index = idx;
        w.act_value = val;
        // weight lanes carry junk on an activation write
        {w.weight_0, w.weight_1, w.weight_2, w.weight_3,
         w.weight_4, w.weight_5, w.weight_6, w.weight_7} = {$urandom, $urandom};
        return w;
    endfunction

    function automatic t_in_word mk_beat(logic [8*LANES-1:0] wv);
        t_in_word w;
        w.kind      = KIND_WEIGHT;
        w.act_index = IDX_W'($urandom);
        w.act_value = VAL_W'($urandom);
        {w.weight_0, w.weight_1, w.weight_2, w.weight_3,
         w.weight_4, w.weight_5, w.weight_6, w.weight_7} = wv;
        return w;
    endfunction

    function automatic logic [8*LANES-1:0] rand_weights();
        logic [8*LANES-1:0] wv;
        for (int l = 0; l < LANES; l++)
            wv[8*l +: 8] = rand_byte();
        return wv;
    endfunction

    // Offer one word, optionally after a gap, and hold it until taken.
    task automatic send_word(t_in_word w, bit typed, logic signed [SUM_W-1:0] want);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        mac_update(w, typed, want);
        if (w.kind == KIND_ACT) writes_sent++;
        else beats_sent++;
    endtask

    // Wait out every queued sum, then let the pipeline empty.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_sizes(logic [CFG_W-1:0] k_val, logic [CFG_W-1:0] n_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_K_LEN;
        i_cfg_data  <= k_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        k_reg = k_val;
        i_cfg_index <= REG_N_LEN;
        i_cfg_data  <= n_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_reg = n_val;
        i_cfg_valid <= 1'b0;
    endtask

    // Receive side: check each accepted word, drive stall bursts and the hold.
    initial begin
        int stall_left;
        t_out_word exp_word;
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_sums.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("tb_top: unexpected word ch=%0d sum=%0d last=%0b",
                                 o_data.channel, o_data.sum, o_data.last);
                end else begin
                    exp_word = pending_sums.pop_front();
                    sums_checked++;
                    if (o_data.channel !== exp_word.channel || o_data.sum !== exp_word.sum ||
                        o_data.last !== exp_word.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("tb_top: mismatch exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     exp_word.channel, exp_word.sum, exp_word.last,
                                     o_data.channel, o_data.sum, o_data.last);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(0, 10);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if no channel moves a word for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: no progress for %0d cycles", QUIET_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        t_size_phase ph;
        int          sent;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data       <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= REG_K_LEN;
        i_cfg_data   <= '0;
        idle_pct     = 10;
        hold_request = 1'b0;
        errors       = 0;
        sums_checked = 0;
        beats_sent   = 0;
        writes_sent  = 0;
        cur_pos      = 0;
        cur_base     = 0;
        k_reg        = K_LEN_RESET;
        n_reg        = N_LEN_RESET;
        for (int l = 0; l < LANES; l++) lane_acc[l] = 0;
        for (int i = 0; i < MAX_K_DEF; i++) begin
            act_mem[i]     = '0;
            act_written[i] = 1'b0;
        end

        // one-beat dot products: typed beats carry sums read off the operands
        dir_rows[0]  = '{mk_act(12'd0, 8'h80), 1'b0, '0};
        dir_rows[1]  = '{mk_beat({8{8'h80}}), 1'b1, 28'sd16384};
        dir_rows[2]  = '{mk_beat({8{8'h7F}}), 1'b1, -28'sd16256};
        dir_rows[3]  = '{mk_act(12'd0, 8'h7F), 1'b0, '0};
        dir_rows[4]  = '{mk_beat({8{8'h7F}}), 1'b1, 28'sd16129};
        dir_rows[5]  = '{mk_beat({8{8'h80}}), 1'b1, -28'sd16256};
        dir_rows[6]  = '{mk_act(12'd4095, 8'h80), 1'b0, '0};
        dir_rows[7]  = '{mk_act(12'hAAA, 8'h55), 1'b0, '0};
        dir_rows[8]  = '{mk_act(12'd0, 8'h00), 1'b0, '0};
        dir_rows[9]  = '{mk_beat(64'h807F01FF_55AA7F80), 1'b1, 28'sd0};
        dir_rows[10] = '{mk_act(12'd0, 8'h01), 1'b0, '0};
        dir_rows[11] = '{mk_beat(64'h80FF0001_023F407F), 1'b0, '0};
        dir_rows[12] = '{mk_act(12'd0, 8'hFF), 1'b0, '0};
        dir_rows[13] = '{mk_beat(64'h7F8001FF_80017FFF), 1'b0, '0};
        dir_rows[14] = '{mk_beat(64'h0), 1'b1, 28'sd0};
        dir_rows[15] = '{mk_act(12'h555, 8'hAA), 1'b0, '0};

        // k, n, beats, idle %, receiver hold; beats that stop short of k leave a
        // group open across the next size change
        phases[0]  = '{13'd0,    13'd8,    12, 10, 1'b0};
        phases[1]  = '{13'd3,    13'd24,   30, 25, 1'b0};
        phases[2]  = '{13'd7,    13'd13,   35, 10, 1'b0};
        phases[3]  = '{13'd1,    13'd4096, 40,  0, 1'b1};
        phases[4]  = '{13'd8191, 13'd8191,  6, 10, 1'b0};
        phases[5]  = '{13'd2,    13'd5,     9, 25, 1'b0};
        phases[6]  = '{13'd4096, 13'd8,     5, 10, 1'b0};
        phases[7]  = '{13'd4,    13'd8190, 40, 10, 1'b0};
        phases[8]  = '{13'd16,   13'd4095, 64, 25, 1'b0};
        phases[9]  = '{13'd5,    13'd0,    45, 10, 1'b0};
        phases[10] = '{13'd3,    13'd16,   36,  0, 1'b0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_sizes(13'd1, 13'd16);
        for (int r = 0; r < N_DIRECTED; r++)
            send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);

        for (int p = 0; p < N_PHASES; p++) begin
            ph = phases[p];
            drain();
            program_sizes(ph.k_val, ph.n_val);
            idle_pct = ph.idle;
            if (ph.hold) hold_request = 1'b1;
            sent = 0;
            while (sent < ph.beats) begin
                if ($urandom_range(0, 99) < 15)
                    send_word(mk_act(IDX_W'($urandom), rand_byte()), 1'b0, '0);
                // never let a beat read an activation that was never written
                if (!act_written[cur_pos])
                    send_word(mk_act(IDX_W'(cur_pos), rand_byte()), 1'b0, '0);
                send_word(mk_beat(rand_weights()), 1'b0, '0);
                sent++;
            end
        end
        drain();

        $display("tb_top: %0d weight beats and %0d activation writes sent, %0d sums checked",
                 beats_sent, writes_sent, sums_checked);
        $display("tb_top: %0d size settings incl. k of 0/1/4096/8191 and n of 0/8/4096/8191",
                 N_PHASES + 1);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
design/i8mvm_pkg.sv
design/i8mvm_lane.sv
design/i8mvm_merge.sv
design/int8_matrix_vector_multiply_core.sv
dv/tb_top.sv
